### hdl/spherical_fov_point_filter_unit_assert.svh
// Assertion macros used by the checker file sfov_checker.sv.
`ifndef SPHERICAL_FOV_POINT_FILTER_UNIT_ASSERT_SVH
`define SPHERICAL_FOV_POINT_FILTER_UNIT_ASSERT_SVH
// Property that must hold on every clock edge outside reset.
`define SFOV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property that is checked during reset as well.
`define SFOV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### hdl/sfov_pkg.sv
// ---------------------------------------------------------------------------
// sfov_pkg
// Types, constants and tables of the spherical field-of-view point filter.
// ---------------------------------------------------------------------------
package sfov_pkg;
    localparam int ANGLE_BITS = 16;
    localparam int COORD_BITS = 20;
    localparam int GUARD      = 28;
    localparam int ITERS      = 30;
    // Datapath width: coordinate, guard bits, CORDIC growth and sign.
    localparam int DW         = COORD_BITS + GUARD + 3;
    localparam int AW         = 34;
    localparam int NREGS      = 8;
    localparam int REG_W      = 16;
    localparam int IDX_W      = 3;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;
    localparam logic [31:0] KGAIN_Q30 = 32'd1768195363;

    // Configuration register indexes.
    typedef enum logic [IDX_W-1:0] {
        REG_FRONT_POLAR_LOW  = 3'd0,
        REG_FRONT_POLAR_HIGH = 3'd1,
        REG_FRONT_AZ_LOW     = 3'd2,
        REG_FRONT_AZ_HIGH    = 3'd3,
        REG_SIDE_POLAR_LOW   = 3'd4,
        REG_SIDE_POLAR_HIGH  = 3'd5,
        REG_SIDE_AZ_LOW      = 3'd6,
        REG_SIDE_AZ_HIGH     = 3'd7
    } reg_idx_t;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [ANGLE_BITS-1:0] angle_t;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        logic   work;   // valid and not at the origin
        logic   last;
    } item_t;

    // Arctangent table, 2^32 units per turn.
    function automatic logic [AW-1:0] atan_tab(input int i);
        logic [AW-1:0] t;
        begin
            unique case (i)
                0: t = 34'd536870912;  1: t = 34'd316933406;  2: t = 34'd167458907;
                3: t = 34'd85004756;   4: t = 34'd42667331;   5: t = 34'd21354465;
                6: t = 34'd10679838;   7: t = 34'd5340245;    8: t = 34'd2670163;
                9: t = 34'd1335087;    10: t = 34'd667544;    11: t = 34'd333772;
                12: t = 34'd166886;    13: t = 34'd83443;     14: t = 34'd41722;
                15: t = 34'd20861;     16: t = 34'd10430;     17: t = 34'd5215;
                18: t = 34'd2608;      19: t = 34'd1304;      20: t = 34'd652;
                21: t = 34'd326;       22: t = 34'd163;       23: t = 34'd81;
                24: t = 34'd41;        25: t = 34'd20;        26: t = 34'd10;
                27: t = 34'd5;         28: t = 34'd3;         29: t = 34'd1;
                default: t = '0;
            endcase
            return t;
        end
    endfunction

    // Round a 2^32-unit angle to ANGLE_BITS units, half up, modulo a turn.
    function automatic angle_t to_angle(input logic [AW-1:0] a);
        logic [31:0] r;
        begin
            r = a[31:0] + (32'd1 << (31 - ANGLE_BITS));
            return r[31 -: ANGLE_BITS];
        end
    endfunction

    // Register value rescaled to ANGLE_BITS units.
    function automatic angle_t reg_angle(input logic [REG_W-1:0] r);
        logic [REG_W+ANGLE_BITS-1:0] w;
        begin
            w = {{ANGLE_BITS{1'b0}}, r} << ANGLE_BITS;
            return w[REG_W +: ANGLE_BITS];
        end
    endfunction

    // Range test; a range whose low end exceeds its high end wraps.
    function automatic logic in_range(input angle_t a, input angle_t lo, input angle_t hi);
        begin
            if (lo <= hi)
                return (a >= lo) && (a <= hi);
            return (a >= lo) || (a <= hi);
        end
    endfunction
endpackage

### hdl/sfov_if.sv
// ---------------------------------------------------------------------------
// sfov_in_if / sfov_out_if
// Valid/ready channels for points and classified results.
// ---------------------------------------------------------------------------
interface sfov_in_if;
    import sfov_pkg::*;
    logic   valid;
    logic   ready;
    coord_t x_coord;
    coord_t y_coord;
    coord_t z_coord;
    logic   point_valid;
    logic   last_point;
    modport source (output valid, x_coord, y_coord, z_coord, point_valid, last_point,
                    input ready);
    modport sink (input valid, x_coord, y_coord, z_coord, point_valid, last_point,
                  output ready);
endinterface

interface sfov_out_if;
    import sfov_pkg::*;
    logic   valid;
    logic   ready;
    logic   keep;
    logic   in_front;
    logic   in_side;
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   out_last;
    modport source (output valid, keep, in_front, in_side, out_x, out_y, out_z, out_last,
                    input ready);
    modport sink (input valid, keep, in_front, in_side, out_x, out_y, out_z, out_last,
                  output ready);
endinterface

### hdl/sfov_front.sv
// ---------------------------------------------------------------------------
// sfov_front
// Accepts points, classifies them and queues them for the angle pipeline.
// ---------------------------------------------------------------------------
module sfov_front
    import sfov_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    sfov_in_if.sink in_ch,
    output item_t q_item,
    output logic  q_valid,
    input  logic  q_pop
);
    item_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_reg, wr_next, rd_reg, rd_next;
    logic [QPTR_W:0]    cnt_reg, cnt_next;
    logic               push;
    item_t              cls;

    // Classification of the incoming point.
    always_comb
    begin
        cls.x    = in_ch.x_coord;
        cls.y    = in_ch.y_coord;
        cls.z    = in_ch.z_coord;
        cls.last = in_ch.last_point;
        cls.work = in_ch.point_valid &&
                   ((in_ch.x_coord != '0) || (in_ch.y_coord != '0) || (in_ch.z_coord != '0));
    end

    assign in_ch.ready = (cnt_reg != (QPTR_W+1)'(QDEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign q_valid     = (cnt_reg != '0);
    assign q_item      = mem_reg[rd_reg];

    // Queue pointers and fill count.
    always_comb
    begin
        wr_next  = push  ? wr_reg + 1'b1 : wr_reg;
        rd_next  = q_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= cls;
    end
endmodule

### hdl/sfov_back.sv
// ---------------------------------------------------------------------------
// sfov_back
// Two pipelined CORDIC passes (azimuth, then polar) and the window tests.
// ---------------------------------------------------------------------------
module sfov_back
    import sfov_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t q_item,
    input  logic  q_valid,
    output logic  q_pop,
    input  logic [REG_W-1:0] regs [NREGS],
    sfov_out_if.source out_ch
);
    localparam int NST = 2 * ITERS;

    typedef struct packed {
        logic signed [DW-1:0] cx;
        logic signed [DW-1:0] cy;
        logic signed [AW-1:0] acc;
        logic signed [AW-1:0] az;
        logic                 zneg;
        item_t                it;
    } stage_t;

    stage_t st_reg  [NST];
    logic   vld_reg [NST];
    logic   adv;

    // Output holding register.
    logic   ov_reg;
    logic   keep_reg, fr_reg, sd_reg, last_reg;
    coord_t ox_reg, oy_reg, oz_reg;

    // The whole pipeline moves when the output slot frees up.
    assign adv   = !ov_reg || out_ch.ready;
    assign q_pop = q_valid && adv;

    // Stage 0: fold x into the right half plane and scale.
    stage_t s0;
    always_comb
    begin
        logic signed [DW-1:0] xs, ys;
        xs = DW'(q_item.x);
        ys = DW'(q_item.y);
        s0      = '0;
        s0.it   = q_item;
        s0.zneg = q_item.z[COORD_BITS-1];
        if (q_item.x[COORD_BITS-1])
        begin
            s0.cx  = (-xs) <<< GUARD;
            s0.cy  = (-ys) <<< GUARD;
            s0.acc = AW'(64'sd2147483648);
        end
        else
        begin
            s0.cx  = xs <<< GUARD;
            s0.cy  = ys <<< GUARD;
            s0.acc = '0;
        end
    end

    // Polar pass input: |z| times the CORDIC gain, magnitude from the azimuth pass.
    logic [COORD_BITS-1:0]    absz;
    logic [COORD_BITS+31:0]   zk_reg;
    stage_t                   mid_reg;
    logic                     midv_reg;
    stage_t                   p0;
    logic                     xy_zero;
    always_comb
    begin
        stage_t a;
        a = st_reg[ITERS-1];
        absz = a.it.z[COORD_BITS-1] ? COORD_BITS'(-a.it.z) : a.it.z;
    end

    // Generate the two CORDIC chains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                vld_reg[i] <= 1'b0;
            midv_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= q_valid;
            for (int i = 1; i < ITERS; i++)
                vld_reg[i] <= vld_reg[i-1];
            midv_reg <= vld_reg[ITERS-1];
            vld_reg[ITERS] <= midv_reg;
            for (int i = ITERS + 1; i < NST; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Azimuth iterations 0..ITERS-1; stage i holds the result after iteration i.
            st_reg[0] <= step(s0, 0);
            for (int i = 1; i < ITERS; i++)
                st_reg[i] <= step(st_reg[i-1], i);
            // Register the gain product, then restart the chain on (z*K, magnitude).
            zk_reg  <= ({{32{1'b0}}, absz} * {{COORD_BITS{1'b0}}, KGAIN_Q30}) >> (30 - GUARD);
            mid_reg <= st_reg[ITERS-1];
            st_reg[ITERS] <= step(p0, 0);
            for (int i = ITERS + 1; i < 2 * ITERS; i++)
                st_reg[i] <= step(st_reg[i-1], i - ITERS);
        end
    end

    // Polar pass setup from the registered azimuth result.
    always_comb
    begin
        xy_zero = (mid_reg.it.x == '0) && (mid_reg.it.y == '0);
        p0      = mid_reg;
        p0.az   = xy_zero ? '0 : mid_reg.acc;
        p0.cx   = DW'(signed'({1'b0, zk_reg}));
        p0.cy   = xy_zero ? '0 : mid_reg.cx;
        p0.acc  = '0;
    end

    function automatic stage_t step(input stage_t s, input int i);
        stage_t r;
        logic signed [DW-1:0] dx, dy;
        begin
            r  = s;
            dx = s.cy >>> i;
            dy = s.cx >>> i;
            if (!s.cy[DW-1])
            begin
                r.cx  = s.cx + dx;
                r.cy  = s.cy - dy;
                r.acc = s.acc + atan_tab(i);
            end
            else
            begin
                r.cx  = s.cx - dx;
                r.cy  = s.cy + dy;
                r.acc = s.acc - atan_tab(i);
            end
            return r;
        end
    endfunction

    // Final: clamp polar, mirror for negative z, round and test windows.
    stage_t fin;
    angle_t azim, polar;
    logic   front, side;
    always_comb
    begin
        logic signed [AW-1:0] pol;
        fin = st_reg[2*ITERS-1];
        pol = fin.acc;
        if (pol < 0)
            pol = '0;
        if (pol > AW'(64'sd1073741824))
            pol = AW'(64'sd1073741824);
        if (fin.zneg)
            pol = AW'(64'sd2147483648) - pol;
        azim  = to_angle(fin.az);
        polar = to_angle(pol);
        front = fin.it.work &&
                in_range(polar, reg_angle(regs[REG_FRONT_POLAR_LOW]),
                         reg_angle(regs[REG_FRONT_POLAR_HIGH])) &&
                in_range(azim, reg_angle(regs[REG_FRONT_AZ_LOW]),
                         reg_angle(regs[REG_FRONT_AZ_HIGH]));
        side  = fin.it.work &&
                in_range(polar, reg_angle(regs[REG_SIDE_POLAR_LOW]),
                         reg_angle(regs[REG_SIDE_POLAR_HIGH])) &&
                in_range(azim, reg_angle(regs[REG_SIDE_AZ_LOW]),
                         reg_angle(regs[REG_SIDE_AZ_HIGH]));
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= vld_reg[2*ITERS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            keep_reg <= front || side;
            fr_reg   <= front;
            sd_reg   <= side;
            ox_reg   <= fin.it.x;
            oy_reg   <= fin.it.y;
            oz_reg   <= fin.it.z;
            last_reg <= fin.it.last;
        end
    end

    assign out_ch.valid    = ov_reg;
    assign out_ch.keep     = keep_reg;
    assign out_ch.in_front = fr_reg;
    assign out_ch.in_side  = sd_reg;
    assign out_ch.out_x    = ox_reg;
    assign out_ch.out_y    = oy_reg;
    assign out_ch.out_z    = oz_reg;
    assign out_ch.out_last = last_reg;
endmodule

### hdl/spherical_fov_point_filter_unit.sv
// Datapath: input queue, two 30-stage CORDIC chains with a register between them, then the output register.
// Throughput: one point per cycle while the output accepts results, set by the fully pipelined CORDIC stages.
// A four-entry queue keeps accepting input while the output stalls, until the queue is full.
// Reset: asynchronous active-low; clears valid flags and loads the window registers.
// ---------------------------------------------------------------------------
// spherical_fov_point_filter_unit
// Top level: window registers, point front end and angle back end.
// ---------------------------------------------------------------------------
module spherical_fov_point_filter_unit
    import sfov_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    sfov_in_if.sink          in_ch,
    sfov_out_if.source       out_ch,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0] cfg_data
);
    logic [REG_W-1:0] regs_reg [NREGS];
    item_t q_item;
    logic  q_valid, q_pop;

    // Window registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[REG_FRONT_POLAR_LOW]  <= 16'd0;
            regs_reg[REG_FRONT_POLAR_HIGH] <= 16'd32768;
            regs_reg[REG_FRONT_AZ_LOW]     <= 16'd60076;
            regs_reg[REG_FRONT_AZ_HIGH]    <= 16'd5461;
            regs_reg[REG_SIDE_POLAR_LOW]   <= 16'd14564;
            regs_reg[REG_SIDE_POLAR_HIGH]  <= 16'd20935;
            regs_reg[REG_SIDE_AZ_LOW]      <= 16'd182;
            regs_reg[REG_SIDE_AZ_HIGH]     <= 16'd0;
        end
        else if (cfg_we)
            regs_reg[cfg_index] <= cfg_data;
    end

    sfov_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    sfov_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_item  (q_item),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .regs    (regs_reg),
        .out_ch  (out_ch)
    );
endmodule

### hdl/sfov_checker.sv
// ---------------------------------------------------------------------------
// sfov_checker
// Port-level checks of the filter's output handshake and result flags.
// ---------------------------------------------------------------------------
`include "spherical_fov_point_filter_unit_assert.svh"
module sfov_checker
    import sfov_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic keep,
    input logic in_front,
    input logic in_side,
    input logic out_last
);
    `SFOV_ASSERT(a_keep_union, out_valid |-> (keep == (in_front || in_side)), "keep mismatch")
    `SFOV_ASSERT(a_hold, (out_valid && !out_ready) |=> (out_valid && $stable(keep) && $stable(out_last)), "stalled result changed")
    `SFOV_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "output valid in reset")
endmodule

bind spherical_fov_point_filter_unit sfov_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .keep      (out_ch.keep),
    .in_front  (out_ch.in_front),
    .in_side   (out_ch.in_side),
    .out_last  (out_ch.out_last)
);
